// ----- src/olvd_pkg.sv -----
`default_nettype none

package olvd_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 2'd0,
    OP_POP_FRONT    = 2'd1,
    OP_POP_BACK     = 2'd2,
    OP_DELETE_VALUE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Commands from the controller to the datapath, one cycle each.
  typedef struct packed {
    logic    load_val;
    logic    do_append;
    logic    pop_front;
    logic    dec_count;
    logic    idx_clear;
    logic    idx_inc;
    logic    rd_cur;
    logic    rd_next;
    logic    wr_shift;
    logic    set_status;
    status_t status_code;
    logic    load_out;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
    logic slot_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/olvd_ram.sv -----
`default_nettype none

module olvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/olvd_ctrl.sv -----
`default_nettype none

module olvd_ctrl
  import olvd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] opcode,
  input  wire dp_stat_t        stat,
  output      logic            in_ready,
  output      ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RESULT;
          cmd.set_status = 1'b1;
          cmd.status_code = ST_OK;
          if (opcode_t'(opcode) == OP_APPEND) begin
            if (stat.full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.do_append = 1'b1;
            end
          end else if (stat.empty) begin
            cmd.status_code = ST_EMPTY;
          end else begin
            unique case (opcode_t'(opcode))
              OP_POP_FRONT: begin
                cmd.pop_front = 1'b1;
              end
              OP_POP_BACK: begin
                cmd.dec_count = 1'b1;
              end
              default: begin
                // search starts at the front
                cmd.set_status = 1'b0;
                cmd.load_val   = 1'b1;
                cmd.idx_clear  = 1'b1;
                state_next     = S_SCAN_RD;
              end
            endcase
          end
        end
      end
      S_SCAN_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          state_next = S_SHIFT_RD;
        end else if (stat.last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_next      = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.last) begin
          cmd.dec_count   = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_RESULT;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_RESULT: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/olvd_dp.sv -----
`default_nettype none

module olvd_dp
  import olvd_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic [DATA_W-1:0]   item_value,
  input  wire logic                out_ready,
  output      dp_stat_t            stat,
  output      logic                out_valid,
  output      logic [STATUS_W-1:0] status,
  output      logic [COUNT_W-1:0]  entry_count
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] val;
  status_t           st;

  logic [IDX_W-1:0]  idx_plus;
  logic [IDX_W-1:0]  head_plus;
  logic [IDX_W-1:0]  wr_off;
  logic [IDX_W-1:0]  rd_off;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic              rd_en;

  // Logical position to cell address: add head, fold once past the depth.
  function automatic logic [IDX_W-1:0] wrap_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(LIST_DEPTH)) begin
      sum = sum - SUM_W'(LIST_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign idx_plus  = idx + IDX_W'(1);
  assign head_plus = wrap_addr(head, IDX_W'(1));

  assign wr_en   = cmd.do_append | cmd.wr_shift;
  assign wr_off  = cmd.do_append ? count[IDX_W-1:0] : idx;
  assign wr_data = cmd.do_append ? item_value : rd_data;
  assign wr_addr = wrap_addr(head, wr_off);

  assign rd_en   = cmd.rd_cur | cmd.rd_next;
  assign rd_off  = cmd.rd_next ? idx_plus : idx;
  assign rd_addr = wrap_addr(head, rd_off);

  olvd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign stat.full      = (count == CNT_W'(LIST_DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.match     = (rd_data == val);
  assign stat.last      = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign stat.slot_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.do_append) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_front || cmd.dec_count) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.pop_front) begin
        head <= head_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_val) begin
      val <= item_value;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus;
    end
    if (cmd.set_status) begin
      st <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= st;
      entry_count <= COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

// ----- src/ordered_list_with_value_delete_top.sv -----
// Bounded ordered list of signed 32-bit values with delete by value.
// Input channel (in_valid/in_ready) carries one command per transaction:
// opcode (append, remove front, remove back, remove first equal value) and
// item_value. Output channel (out_valid/out_ready) returns one transaction per
// command: status (ok, empty, not found, full) and the entry count after it.
// Commands are taken one at a time; in_ready is high only while the
// controller is idle.
// Append, remove front/back and any rejected command go from accept straight
// to the result state. Remove-value scans from the front, one entry compared
// at a time (registered RAM read, then compare), then moves each later entry
// one place forward. The single-port-read list RAM sets this pacing.
// Reset: rst (synchronous, active high) empties the list and drops any
// pending result; the list cells themselves are not cleared.
// Receiver stall: the result holds in the output register, unchanged, until
// out_ready; the next command's result waits in the result state meanwhile.
`default_nettype none

module ordered_list_with_value_delete_top
  import olvd_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [DATA_W-1:0]   item_value,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [STATUS_W-1:0] status,
  output      logic [COUNT_W-1:0]  entry_count
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: decode the command, sequence the scan and the shift.
  olvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath: list RAM as a ring (head + count), scan index, output register.
  olvd_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item_value  (item_value),
    .out_ready   (out_ready),
    .stat        (stat),
    .out_valid   (out_valid),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

// ----- src/olvd_checker.sv -----
`default_nettype none

module olvd_checker
  import olvd_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [COUNT_W-1:0]  entry_count
);

  // Result holds while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result changed or dropped under stall");

  // One command at a time: no accept in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while another is in progress");

  // No result straight after reset.
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A full rejection reports the depth; an empty rejection reports zero.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(LIST_DEPTH))
    else $error("full status with wrong count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind ordered_list_with_value_delete_top olvd_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .entry_count (entry_count)
);

`default_nettype wire
